>>> hw/rtl/r3c_pkg.sv
// Shared types and constants of the raster 3x3 convolution block.
// Used by the column cells, the multiply-accumulate pipeline and the top level.
`timescale 1ns / 1ps

package r3c_pkg;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 20;
  localparam int ROW_W       = 12;
  localparam int KROW_W      = 24;
  localparam int IW_W        = 11;
  localparam int IH_W        = 13;
  localparam int MAX_HEIGHT  = 4096;
  localparam int IMG_W_RESET = 640;
  localparam int IMG_H_RESET = 480;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int TAPS        = 9;
  localparam int EMIT_N      = 4;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = 2;
  localparam int OCC_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

  // Bit positions of the pending-result mask, in emission order.
  localparam int EM_ABOVE       = 0;
  localparam int EM_BOTTOM      = 1;
  localparam int EM_ABOVE_EDGE  = 2;
  localparam int EM_BOTTOM_EDGE = 3;

  typedef logic [2:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    logic bottom_row;
    logic top_dup;
  } row_sel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } res_tag_t;

endpackage

>>> hw/rtl/r3c_line_store.sv
// Line store memory holding the two previous image rows side by side in one word.
// Single write port and one registered read port; no package dependencies.
`timescale 1ns / 1ps

module r3c_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/r3c_col_cell.sv
// One column cell of the 3x3 window: stores three pixels and passes them to its neighbor.
// Also picks the top, middle and bottom taps for edge replication. Depends on r3c_pkg.
`timescale 1ns / 1ps

module r3c_col_cell (
  input  logic              clk,
  input  logic              shift,
  input  r3c_pkg::pix_col_t col_in,
  input  r3c_pkg::row_sel_t sel,
  output r3c_pkg::pix_col_t col_out,
  output r3c_pkg::pix_col_t tap_out
);
  import r3c_pkg::*;

  pix_col_t col_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  always_comb begin
    tap_out[2] = col_r[2];
    if (sel.bottom_row) begin
      tap_out[0] = col_r[1];
      tap_out[1] = col_r[2];
    end else begin
      tap_out[0] = sel.top_dup ? col_r[1] : col_r[0];
      tap_out[1] = col_r[1];
    end
  end

endmodule

>>> hw/rtl/r3c_mac.sv
// Multiply-accumulate pipeline: nine products, three partial sums, saturated total.
// Two register stages; the total leaves combinationally. Depends on r3c_pkg.
`timescale 1ns / 1ps

module r3c_mac #(
  parameter int COEFF_BITS = 8,
  parameter int COL_W      = 10
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  input  logic [r3c_pkg::TAPS-1:0][r3c_pkg::PIX_W-1:0]     in_pix,
  input  logic [r3c_pkg::TAPS-1:0][COEFF_BITS-1:0]         in_coef,
  input  r3c_pkg::res_tag_t                                in_tag,
  input  logic [COL_W-1:0]                                 in_col,
  output logic                                             out_valid,
  output logic [r3c_pkg::SUM_W-1:0]                        out_sum,
  output r3c_pkg::res_tag_t                                out_tag,
  output logic [COL_W-1:0]                                 out_col
);
  import r3c_pkg::*;

  localparam int PROD_W = COEFF_BITS + PIX_W + 1;
  localparam int PART_W = PROD_W + 2;
  localparam int TOT_W  = (PROD_W + 4 > SUM_W + 1) ? PROD_W + 4 : SUM_W + 1;
  localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [TOT_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] prod_r [TAPS];
  logic signed [PART_W-1:0] part_r [3];
  logic                     v1_r;
  logic                     v2_r;
  res_tag_t                 tag1_r;
  res_tag_t                 tag2_r;
  logic [COL_W-1:0]         col1_r;
  logic [COL_W-1:0]         col2_r;
  logic signed [TOT_W-1:0]  tot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= $signed({1'b0, in_pix[k]}) * $signed(in_coef[k]);
      end
      tag1_r <= in_tag;
      col1_r <= in_col;
    end
    if (v1_r) begin
      for (int g = 0; g < 3; g++) begin
        part_r[g] <= PART_W'(prod_r[3*g]) + PART_W'(prod_r[3*g+1]) + PART_W'(prod_r[3*g+2]);
      end
      tag2_r <= tag1_r;
      col2_r <= col1_r;
    end
  end

  always_comb begin
    tot = TOT_W'(part_r[0]) + TOT_W'(part_r[1]) + TOT_W'(part_r[2]);
    if (tot > SAT_HI) begin
      out_sum = SAT_HI[SUM_W-1:0];
    end else if (tot < SAT_LO) begin
      out_sum = SAT_LO[SUM_W-1:0];
    end else begin
      out_sum = tot[SUM_W-1:0];
    end
  end

  assign out_valid = v2_r;
  assign out_tag   = tag2_r;
  assign out_col   = col2_r;

endmodule

>>> hw/rtl/raster_3x3_convolution.sv
// Top level of the raster 3x3 convolution block with edge replication.
// Uses r3c_pkg, r3c_line_store, r3c_col_cell and r3c_mac.
`timescale 1ns / 1ps

// Pixels enter in raster order, one word per clock while in_tready is high, and frame_start on
// in_tuser restarts the row and column counters. Each pixel occupies the result sequencer until
// the results it causes are issued, and holds it even if it causes none: one result for most
// pixels, two at the end of any row but the first and at every column but the first of the last
// row, and four for the last pixel of the last row. Results leave one per clock while out_tready
// is high; after its pixel is accepted, a result passes through the line store read, the window
// load, the product stage, the partial sum stage and the output queue. The line store is a
// single memory of MAX_WIDTH words read and written once per pixel; it needs no clearing after
// reset. Configuration must be written while the block is idle.
module raster_3x3_convolution #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 8,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int OUT_DW    = ((r3c_pkg::SUM_W + r3c_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [r3c_pkg::PIX_W-1:0]        in_tdata,   // pixel
  input  logic                             in_tuser,   // frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_DW-1:0]                out_tdata,  // conv_sum, out_row, out_col, zero pad
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [r3c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [r3c_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import r3c_pkg::*;

  localparam int WX   = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
  localparam int KX_W = (3 * COEFF_BITS > KROW_W) ? 3 * COEFF_BITS : KROW_W;
  localparam int MW   = 2 * PIX_W;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic             last;
  } entry_t;

  logic [KROW_W-1:0] k_top_r;
  logic [KROW_W-1:0] k_mid_r;
  logic [KROW_W-1:0] k_bot_r;
  logic [IW_W-1:0]   img_w_r;
  logic [IH_W-1:0]   img_h_r;

  logic [COL_W-1:0]  cnt_col_r;
  logic [ROW_W-1:0]  cnt_row_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [WX-1:0]     iw_x;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic [COL_W-1:0]  col_raw;
  logic [ROW_W-1:0]  row_raw;
  logic [COL_W-1:0]  c_cur;
  logic [ROW_W-1:0]  r_cur;
  logic              c_end;
  logic              r_end;
  logic [EMIT_N-1:0] pend_new;
  logic              accept;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [COL_W-1:0]  s1_c_r;
  logic [ROW_W-1:0]  s1_r_r;
  logic              s1_cfirst_r;
  logic              s1_rone_r;
  logic [EMIT_N-1:0] s1_pend_r;
  logic              s1_byp_r;
  logic [MW-1:0]     s1_byp_data_r;
  logic              s1_adv;
  logic [MW-1:0]     rd_word;
  logic [MW-1:0]     s1_word;
  logic [MW-1:0]     wr_word;
  pix_col_t          new_col;

  logic              em_valid_r;
  logic [EMIT_N-1:0] em_pend_r;
  logic [EMIT_N-1:0] em_pend_nxt;
  logic [EMIT_N-1:0] em_low;
  logic [COL_W-1:0]  em_c_r;
  logic [ROW_W-1:0]  em_r_r;
  logic              em_cfirst_r;
  logic              em_rone_r;
  logic              em_last;
  logic              em_done;
  logic              em_take;
  logic              em_right;
  logic              issue;
  row_sel_t          row_sel;

  pix_col_t          link_2_1;
  pix_col_t          link_1_0;
  pix_col_t          tap0;
  pix_col_t          tap1;
  pix_col_t          tap2;
  pix_col_t          kcol [3];

  logic [TAPS-1:0][PIX_W-1:0]      mac_pix;
  logic [TAPS-1:0][COEFF_BITS-1:0] mac_coef;
  logic [KX_W-1:0]                 k_ext [3];
  res_tag_t                        iss_tag;
  logic [COL_W-1:0]                iss_col;
  logic                            mac_valid;
  logic [SUM_W-1:0]                mac_sum;
  res_tag_t                        mac_tag;
  logic [COL_W-1:0]                mac_col;

  entry_t            fifo_mem [OUT_DEPTH];
  entry_t            head;
  logic [OUT_AW-1:0] wr_ptr_r;
  logic [OUT_AW-1:0] rd_ptr_r;
  logic [OCC_W-1:0]  fifo_cnt_r;
  logic [OCC_W-1:0]  fifo_cnt_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;
  logic              push;
  logic              pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r <= '0;
      k_mid_r <= '0;
      k_bot_r <= '0;
      img_w_r <= IW_W'(IMG_W_RESET);
      img_h_r <= IH_W'(IMG_H_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_TOP: begin
          k_top_r <= cfg_data[KROW_W-1:0];
        end
        REG_KERNEL_MIDDLE: begin
          k_mid_r <= cfg_data[KROW_W-1:0];
        end
        REG_KERNEL_BOTTOM: begin
          k_bot_r <= cfg_data[KROW_W-1:0];
        end
        REG_IMAGE_WIDTH: begin
          img_w_r <= cfg_data[IW_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          img_h_r <= cfg_data[IH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Position of the incoming pixel, clamped to the configured frame size.
  always_comb begin
    iw_x = WX'(img_w_r);
    if (iw_x < WX'(2)) begin
      w_last = COL_W'(1);
    end else if (iw_x > WX'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(iw_x - WX'(1));
    end
    if (img_h_r < IH_W'(2)) begin
      h_last = ROW_W'(1);
    end else if (img_h_r > IH_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(img_h_r - IH_W'(1));
    end
    col_raw = in_tuser ? '0 : cnt_col_r;
    row_raw = in_tuser ? '0 : cnt_row_r;
    c_cur   = (col_raw > w_last) ? w_last : col_raw;
    r_cur   = (row_raw > h_last) ? h_last : row_raw;
    c_end   = (c_cur == w_last);
    r_end   = (r_cur == h_last);
    pend_new[EM_ABOVE]       = (c_cur != '0) && (r_cur != '0);
    pend_new[EM_BOTTOM]      = (c_cur != '0) && r_end;
    pend_new[EM_ABOVE_EDGE]  = pend_new[EM_ABOVE] && c_end;
    pend_new[EM_BOTTOM_EDGE] = pend_new[EM_BOTTOM] && c_end;
    if (c_end) begin
      col_nxt = '0;
      row_nxt = r_end ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_nxt = c_cur + COL_W'(1);
      row_nxt = r_cur;
    end
  end

  // Handshake and result sequencing.
  always_comb begin
    em_low      = em_pend_r & (~em_pend_r + EMIT_N'(1));
    em_pend_nxt = em_pend_r & ~em_low;
    em_last     = (em_pend_nxt == '0);
    issue       = em_valid_r && (em_pend_r != '0) && (occ_r < OCC_W'(OUT_DEPTH));
    em_done     = em_valid_r && ((em_pend_r == '0) || (issue && em_last));
    em_take     = !em_valid_r || em_done;
    s1_adv      = s1_valid_r && em_take;
    in_tready   = !s1_valid_r || em_take;
    accept      = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_col_r  <= '0;
      cnt_row_r  <= '0;
      s1_valid_r <= 1'b0;
      em_valid_r <= 1'b0;
      em_pend_r  <= '0;
    end else begin
      if (accept) begin
        cnt_col_r  <= col_nxt;
        cnt_row_r  <= row_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (em_take) begin
        em_valid_r <= s1_valid_r;
        em_pend_r  <= s1_valid_r ? s1_pend_r : '0;
      end else if (issue) begin
        em_pend_r  <= em_pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= in_tdata;
      s1_c_r        <= c_cur;
      s1_r_r        <= r_cur;
      s1_cfirst_r   <= (c_cur == COL_W'(1));
      s1_rone_r     <= (r_cur == ROW_W'(1));
      s1_pend_r     <= pend_new;
      s1_byp_r      <= s1_adv && (c_cur == s1_c_r);
      s1_byp_data_r <= wr_word;
    end
    if (s1_adv) begin
      em_c_r      <= s1_c_r;
      em_r_r      <= s1_r_r;
      em_cfirst_r <= s1_cfirst_r;
      em_rone_r   <= s1_rone_r;
    end
  end

  // Line store word: two rows back in the high byte, previous row in the low byte.
  assign s1_word    = s1_byp_r ? s1_byp_data_r : rd_word;
  assign wr_word    = {s1_word[PIX_W-1:0], s1_px_r};
  assign new_col[0] = s1_word[MW-1:PIX_W];
  assign new_col[1] = s1_word[PIX_W-1:0];
  assign new_col[2] = s1_px_r;

  r3c_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (MW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_c_r),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (rd_word)
  );

  // Window: three column cells, newest on the right.
  assign row_sel.bottom_row = em_low[EM_BOTTOM] | em_low[EM_BOTTOM_EDGE];
  assign row_sel.top_dup    = em_rone_r;
  assign em_right           = em_low[EM_ABOVE_EDGE] | em_low[EM_BOTTOM_EDGE];

  r3c_col_cell u_cell2 (
    .clk     (clk),
    .shift   (s1_adv),
    .col_in  (new_col),
    .sel     (row_sel),
    .col_out (link_2_1),
    .tap_out (tap2)
  );

  r3c_col_cell u_cell1 (
    .clk     (clk),
    .shift   (s1_adv),
    .col_in  (link_2_1),
    .sel     (row_sel),
    .col_out (link_1_0),
    .tap_out (tap1)
  );

  r3c_col_cell u_cell0 (
    .clk     (clk),
    .shift   (s1_adv),
    .col_in  (link_1_0),
    .sel     (row_sel),
    .col_out (),
    .tap_out (tap0)
  );

  always_comb begin
    if (em_right) begin
      kcol[0] = tap1;
      kcol[1] = tap2;
    end else begin
      kcol[0] = em_cfirst_r ? tap1 : tap0;
      kcol[1] = tap1;
    end
    kcol[2] = tap2;
    k_ext[0] = KX_W'(k_top_r);
    k_ext[1] = KX_W'(k_mid_r);
    k_ext[2] = KX_W'(k_bot_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mac_pix[3*i+j]  = kcol[j][i];
        mac_coef[3*i+j] = k_ext[i][j*COEFF_BITS +: COEFF_BITS];
      end
    end
    iss_tag.row  = row_sel.bottom_row ? em_r_r : em_r_r - ROW_W'(1);
    iss_tag.last = em_last;
    iss_col      = em_right ? em_c_r : em_c_r - COL_W'(1);
  end

  r3c_mac #(
    .COEFF_BITS (COEFF_BITS),
    .COL_W      (COL_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_pix    (mac_pix),
    .in_coef   (mac_coef),
    .in_tag    (iss_tag),
    .in_col    (iss_col),
    .out_valid (mac_valid),
    .out_sum   (mac_sum),
    .out_tag   (mac_tag),
    .out_col   (mac_col)
  );

  // Output queue; occ_r counts results in the pipeline and in the queue.
  assign push       = mac_valid;
  assign head       = fifo_mem[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = OUT_DW'({head.col, head.row, head.sum});
  assign out_tlast  = head.last;

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (push && !pop) begin
      fifo_cnt_nxt = fifo_cnt_r + OCC_W'(1);
    end else if (pop && !push) begin
      fifo_cnt_nxt = fifo_cnt_r - OCC_W'(1);
    end
    occ_nxt = occ_r;
    if (issue && !pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (pop && !issue) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_nxt;
      occ_r      <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= '{col: mac_col, row: mac_tag.row, sum: mac_sum, last: mac_tag.last};
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(OUT_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= occ_r)
    else $error("queue holds more words than credits taken");

  a_mac_latency: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ##2 push)
    else $error("issued result did not reach the queue two cycles later");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < OCC_W'(OUT_DEPTH)) || pop)
    else $error("write into a full output queue");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for raster_3x3_convolution: streams pixel frames through the block and
// compares every result word with a built-in prediction of the edge-replicated 3x3 correlation.
// Depends on r3c_pkg and the raster_3x3_convolution RTL.
`timescale 1ns / 1ps

module tb;
  import r3c_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int OUT_BITS = 48;
  localparam int SUM_HIGH = 524287;
  localparam int SUM_LOW = -524288;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic [9:0]       col;
    logic             last;
  } conv_result_t;

  class conv_sum_tracker;
    logic [KROW_W-1:0] kernel_rows[3];
    logic [IW_W-1:0]   width_reg;
    logic [IH_W-1:0]   height_reg;
    logic [PIX_W-1:0]  line_prev[MAX_COLS];
    logic [PIX_W-1:0]  line_prev2[MAX_COLS];
    logic [PIX_W-1:0]  win[3][3];
    int                col_count;
    int                row_count;
    int                errors;
    conv_result_t      pending_sums[$];

    function void clear_state();
      foreach (kernel_rows[i]) kernel_rows[i] = '0;
      width_reg = IW_W'(IMG_W_RESET);
      height_reg = IH_W'(IMG_H_RESET);
      foreach (line_prev[i]) begin
        line_prev[i] = '0;
        line_prev2[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_count = 0;
      row_count = 0;
      errors = 0;
      pending_sums.delete();
    endfunction

    function int limit_to(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KERNEL_TOP: kernel_rows[0] = data;
        REG_KERNEL_MIDDLE: kernel_rows[1] = data;
        REG_KERNEL_BOTTOM: kernel_rows[2] = data;
        REG_IMAGE_WIDTH: width_reg = data[IW_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[IH_W-1:0];
        default: ;
      endcase
    endfunction

    function int kernel_sum(int top, int mid, int bot, int lc, int cc, int rc);
      int rsel[3];
      int csel[3];
      int acc;
      logic signed [7:0] coeff;
      rsel[0] = top;
      rsel[1] = mid;
      rsel[2] = bot;
      csel[0] = lc;
      csel[1] = cc;
      csel[2] = rc;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coeff = kernel_rows[i][j*8 +: 8];
          acc += int'(coeff) * int'(win[rsel[i]][csel[j]]);
        end
      end
      return limit_to(acc, SUM_LOW, SUM_HIGH);
    endfunction

    function void push_sum(int s, int row, int col);
      conv_result_t e;
      e.sum = s[SUM_W-1:0];
      e.row = row[ROW_W-1:0];
      e.col = col[9:0];
      e.last = 1'b0;
      pending_sums.push_back(e);
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px, logic frame_start);
      int w;
      int h;
      int c;
      int r;
      int left;
      int prior_count;
      logic [PIX_W-1:0] up2;
      logic [PIX_W-1:0] up1;
      w = limit_to(int'(width_reg), 2, MAX_COLS);
      h = limit_to(int'(height_reg), 2, MAX_HEIGHT);
      if (frame_start) begin
        col_count = 0;
        row_count = 0;
      end
      c = (col_count < w - 1) ? col_count : w - 1;
      r = (row_count < h - 1) ? row_count : h - 1;
      up2 = line_prev2[c];
      up1 = line_prev[c];
      line_prev2[c] = up1;
      line_prev[c] = px;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      prior_count = pending_sums.size();
      if (c >= 1) begin
        left = (c == 1) ? 1 : 0;
        if (r >= 1) push_sum(kernel_sum((r == 1) ? 1 : 0, 1, 2, left, 1, 2), r - 1, c - 1);
        if (r == h - 1) push_sum(kernel_sum(1, 2, 2, left, 1, 2), r, c - 1);
        if (c == w - 1) begin
          if (r >= 1) push_sum(kernel_sum((r == 1) ? 1 : 0, 1, 2, 1, 2, 2), r - 1, c);
          if (r == h - 1) push_sum(kernel_sum(1, 2, 2, 1, 2, 2), r, c);
        end
      end
      if (pending_sums.size() > prior_count) pending_sums[pending_sums.size()-1].last = 1'b1;
      if (c + 1 >= w) begin
        col_count = 0;
        row_count = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_count = c + 1;
        row_count = r;
      end
    endfunction

    function void match_result(logic [SUM_W-1:0] sum, logic [ROW_W-1:0] row, logic [9:0] col,
                               logic last);
      conv_result_t e;
      if (pending_sums.size() == 0) begin
        $error("unexpected result word: conv_sum %0d out_row %0d out_col %0d",
               $signed(sum), row, col);
        errors++;
        return;
      end
      e = pending_sums.pop_front();
      if (sum !== e.sum) begin
        $error("conv_sum: expected %0d, actual %0d", $signed(e.sum), $signed(sum));
        errors++;
      end
      if (row !== e.row) begin
        $error("out_row: expected %0d, actual %0d", e.row, row);
        errors++;
      end
      if (col !== e.col) begin
        $error("out_col: expected %0d, actual %0d", e.col, col);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_BITS-1:0]   out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          in_idle_pct = 13;
  int          out_idle_pct = 54;
  int unsigned cycle_count = 0;
  conv_sum_tracker tracker = new();

  raster_3x3_convolution u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_result(out_tdata[19:0], out_tdata[31:20], out_tdata[41:32], out_tlast);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("raster_3x3_convolution regression: fail");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic frame_start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_pixel(px, frame_start);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.load_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] k_top, k_mid, k_bot, w_data, h_data);
    wait_idle();
    write_reg(REG_KERNEL_TOP, k_top);
    write_reg(REG_KERNEL_MIDDLE, k_mid);
    write_reg(REG_KERNEL_BOTTOM, k_bot);
    write_reg(REG_IMAGE_WIDTH, w_data);
    write_reg(REG_IMAGE_HEIGHT, h_data);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_kernel();
    case ($urandom_range(9))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int item_goal);
    int sent;
    int w;
    int h;
    int total;
    int shape;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    sent = 0;
    while (sent < item_goal) begin
      w_data = CFG_DATA_W'($urandom);
      h_data = CFG_DATA_W'($urandom);
      w_data[IW_W-1:0] = IW_W'(($urandom_range(11) == 0) ? $urandom_range(1)
                                                          : $urandom_range(2, 9));
      h_data[IH_W-1:0] = IH_W'(($urandom_range(11) == 0) ? $urandom_range(1)
                                                          : $urandom_range(2, 6));
      configure(pick_kernel(), pick_kernel(), pick_kernel(), w_data, h_data);
      w = tracker.limit_to(int'(w_data[IW_W-1:0]), 2, MAX_COLS);
      h = tracker.limit_to(int'(h_data[IH_W-1:0]), 2, MAX_HEIGHT);
      total = w * h;
      shape = $urandom_range(9);
      // Mostly whole frames; some are cut short and some carry stray frame starts.
      if (shape == 0) total = $urandom_range(1, total);
      for (int i = 0; i < total; i++) begin
        send_pixel(PIX_W'($urandom_range(255)),
                   (i == 0) || (shape == 1 && $urandom_range(19) == 0));
      end
      sent += total;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] k_top;
    logic [CFG_DATA_W-1:0] k_mid;
    logic [CFG_DATA_W-1:0] k_bot;
    tracker.clear_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 13;
    out_idle_pct = 54;
    configure(24'h808080, 24'h7F7F7F, 24'h01FF00, 24'd3, 24'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF, i == 0);
    // Widths and heights below two are raised to two; the upper data bits are ignored.
    configure(24'h808080, 24'h808080, 24'h808080, 24'hFFF801, 24'hFFE000);
    for (int i = 0; i < 4; i++) send_pixel(8'hFF, i == 0);
    // Shrink the image in mid-frame so that the column counter lies beyond the new width.
    k_top = CFG_DATA_W'($urandom);
    k_mid = CFG_DATA_W'($urandom);
    k_bot = CFG_DATA_W'($urandom);
    configure(k_top, k_mid, k_bot, 24'd4, 24'd3);
    for (int i = 0; i < 7; i++) send_pixel(PIX_W'($urandom_range(255)), i == 0);
    configure(k_top, k_mid, k_bot, 24'd2, 24'd2);
    send_pixel(PIX_W'($urandom_range(255)), 1'b0);
    send_pixel(PIX_W'($urandom_range(255)), 1'b0);
    send_pixel(PIX_W'($urandom_range(255)), 1'b1);
    for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom_range(255)), 1'b0);
    random_frames(80);

    wait_idle();
    in_idle_pct = 54;
    out_idle_pct = 13;
    random_frames(80);
    configure(pick_kernel(), pick_kernel(), pick_kernel(), 24'h0007FF, 24'd2);
    for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom_range(255)), i == 0);

    wait_idle();
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_frames(80);
    configure(pick_kernel(), pick_kernel(), pick_kernel(), 24'd2, 24'h001FFF);
    for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom_range(255)), i == 0);

    wait_idle();
    if (tracker.errors == 0) begin
      $display("raster_3x3_convolution regression: pass");
    end else begin
      $display("raster_3x3_convolution regression: fail");
    end
    $finish;
  end

endmodule
